>>> rtl/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Constants, status codes and the byte-wide CRC-16/CCITT-FALSE update used by
// the command frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

	localparam int FRAME_BYTES = 12;
	localparam int POS_W       = $clog2(FRAME_BYTES);
	localparam int CRC_SPAN    = 10;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [2:0] ST_INCOMPLETE  = 3'd0;
	localparam logic [2:0] ST_VALID       = 3'd1;
	localparam logic [2:0] ST_BAD_VERSION = 3'd2;
	localparam logic [2:0] ST_BAD_LENGTH  = 3'd3;
	localparam logic [2:0] ST_BAD_CRC     = 3'd4;

	localparam logic [1:0] REG_HEADER_FIRST     = 2'd0;
	localparam logic [1:0] REG_HEADER_SECOND    = 2'd1;
	localparam logic [1:0] REG_EXPECTED_VERSION = 2'd2;

	typedef logic [POS_W-1:0] pos_t;

	// Eight shift-and-xor steps, one per bit of the incoming byte, MSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/command_frame_parser_crc16.sv
// ----------------------------------------------------------------------------
// command_frame_parser_crc16
// Byte-stream parser for 12-byte command frames with a two-byte header and a
// little-endian CRC-16/CCITT-FALSE over bytes 0 to 9.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter one item at a time on the in_valid / in_ready channel.
// Every byte gives exactly one result item on the out_valid / out_ready
// channel. The status is incomplete for every byte except the last byte of a
// frame, which reports valid, bad version, bad length or bad CRC. The decoded
// frame fields are nonzero only when the status is valid.
// An accepted byte waits in the input register, and the parse step loads the
// result register. Throughput is one item per cycle while out_ready stays
// high; the CRC is folded in byte by byte, so the eight-step byte-wide CRC
// update is the longest path in the parse step.
// When the receiver stalls, the result register holds its item and the input
// register fills; in_ready then drops until the result is taken. in_ready
// comes combinationally from out_ready through the input stage.
// Reset clears both stages, returns the parser to the header hunt, sets the
// running CRC to 0xFFFF and loads the header and version registers with
// 0xAA, 0x55 and 0x01. Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
module command_frame_parser_crc16 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [15:0]        sequence_number,
	output logic [7:0]         command_mode,
	output logic [7:0]         command_valid,
	output logic signed [15:0] position
);

	localparam cfp_pkg::pos_t LAST_POS = cfp_pkg::pos_t'(cfp_pkg::FRAME_BYTES - 1);
	localparam cfp_pkg::pos_t CRC_END  = cfp_pkg::pos_t'(cfp_pkg::CRC_SPAN);

	// Configuration registers.
	logic [7:0] header_first_q;
	logic [7:0] header_second_q;
	logic [7:0] expected_version_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q     <= 8'hAA;
			header_second_q    <= 8'h55;
			expected_version_q <= 8'h01;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				cfp_pkg::REG_HEADER_FIRST:     header_first_q     <= cfg_data;
				cfp_pkg::REG_HEADER_SECOND:    header_second_q    <= cfg_data;
				cfp_pkg::REG_EXPECTED_VERSION: expected_version_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register. The stage advances whenever the result register is free
	// or is being emptied in the same cycle.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic       advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	// Parser state.
	cfp_pkg::pos_t pos_q;
	logic [15:0]   crc_q;
	logic [7:0]    frame_store_q [cfp_pkg::FRAME_BYTES];

	// Next-state decode for the byte in the input register.
	cfp_pkg::pos_t pos_next;
	cfp_pkg::pos_t store_idx;
	logic          store_we;
	logic          crc_restart;
	logic          crc_we;
	logic [15:0]   crc_next;
	logic          frame_done;

	always_comb begin
		pos_next    = pos_q;
		store_idx   = pos_q;
		store_we    = 1'b0;
		crc_restart = 1'b0;
		crc_we      = 1'b0;
		frame_done  = 1'b0;
		if (pos_q == '0) begin
			if (byte_s1 == header_first_q) begin
				store_idx   = '0;
				store_we    = 1'b1;
				crc_restart = 1'b1;
				crc_we      = 1'b1;
				pos_next    = cfp_pkg::pos_t'(1);
			end
		end else if (pos_q == cfp_pkg::pos_t'(1)) begin
			// A repeated first header byte keeps the hunt at the second byte.
			if (byte_s1 == header_second_q) begin
				store_we = 1'b1;
				crc_we   = 1'b1;
				pos_next = cfp_pkg::pos_t'(2);
			end else if (byte_s1 == header_first_q) begin
				store_idx   = '0;
				store_we    = 1'b1;
				crc_restart = 1'b1;
				crc_we      = 1'b1;
				pos_next    = cfp_pkg::pos_t'(1);
			end else begin
				pos_next = '0;
			end
		end else if (pos_q > LAST_POS) begin
			pos_next = '0;
		end else begin
			store_we = 1'b1;
			crc_we   = (pos_q < CRC_END);
			if (pos_q == LAST_POS) begin
				pos_next   = '0;
				frame_done = 1'b1;
			end else begin
				pos_next = pos_q + cfp_pkg::pos_t'(1);
			end
		end
	end

	assign crc_next = cfp_pkg::crc_byte(crc_restart ? cfp_pkg::CRC_INIT : crc_q, byte_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= cfp_pkg::CRC_INIT;
		end else if (advance) begin
			pos_q <= pos_next;
			if (crc_we) begin
				crc_q <= crc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && store_we) begin
			frame_store_q[store_idx] <= byte_s1;
		end
	end

	// Frame checks. The last byte is still in the input register, so the high
	// CRC byte comes from there rather than from the store.
	logic [2:0]  status_d;
	logic [15:0] rx_crc;

	assign rx_crc = {byte_s1, frame_store_q[10]};

	always_comb begin
		status_d = cfp_pkg::ST_INCOMPLETE;
		if (frame_done) begin
			priority if (frame_store_q[2] != expected_version_q) begin
				status_d = cfp_pkg::ST_BAD_VERSION;
			end else if (frame_store_q[3] != 8'(cfp_pkg::FRAME_BYTES)) begin
				status_d = cfp_pkg::ST_BAD_LENGTH;
			end else if (rx_crc != crc_q) begin
				status_d = cfp_pkg::ST_BAD_CRC;
			end else begin
				status_d = cfp_pkg::ST_VALID;
			end
		end
	end

	// Result register.
	logic [2:0]         status_q;
	logic [15:0]        sequence_q;
	logic [7:0]         mode_q;
	logic [7:0]         cmd_valid_q;
	logic signed [15:0] position_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			if (status_d == cfp_pkg::ST_VALID) begin
				sequence_q  <= {frame_store_q[5], frame_store_q[4]};
				mode_q      <= frame_store_q[6];
				cmd_valid_q <= frame_store_q[7];
				position_q  <= $signed({frame_store_q[9], frame_store_q[8]});
			end else begin
				sequence_q  <= '0;
				mode_q      <= '0;
				cmd_valid_q <= '0;
				position_q  <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign sequence_number = sequence_q;
	assign command_mode    = mode_q;
	assign command_valid   = cmd_valid_q;
	assign position        = position_q;

	// Only the last byte of a frame may produce a final status.
	a_incomplete_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && pos_q != LAST_POS) |=> (status_q == cfp_pkg::ST_INCOMPLETE))
		else $error("final status reported before the frame was complete");

	// Decoded fields are zero unless the frame checked out.
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != cfp_pkg::ST_VALID) |->
		(sequence_q == '0 && mode_q == '0 && cmd_valid_q == '0 && position_q == '0))
		else $error("frame fields nonzero on a status other than valid");

	// A stalled result with a full input register must hold off new bytes.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && valid_s1) |-> !in_ready)
		else $error("input accepted while both stages were full");

	// The parser position never leaves the frame.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (pos_q <= LAST_POS))
		else $error("frame position out of range");

endmodule

>>> tb/command_frame_parser_crc16_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_parser_crc16_test
// Self-checking bench for the command frame parser. Bytes are offered on the
// input channel while a scoreboard tracks its own copy of the parser: header
// hunt, frame buffer, running CRC and the three configuration registers.
// Every result item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module command_frame_parser_crc16_test;

	// Index past the register list. Writes to it must leave the parser alone.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// Cycles without any handshake before the run is declared hung. The longest
	// quiet stretch is the deliberate receiver hold-off in the backpressure test.
	localparam int QUIET_LIMIT = 2000;

	// Number of mismatch lines printed before the report goes quiet.
	localparam int REPORT_LINES = 200;

	typedef logic [7:0] octet_q_t[$];

	typedef struct packed {
		logic [2:0]         status;
		logic [15:0]        sequence_number;
		logic [7:0]         command_mode;
		logic [7:0]         command_valid;
		logic signed [15:0] position;
	} frame_result_t;

	// Ways a generated frame can be damaged. The all-bad frame carries a wrong
	// version, a wrong length and a wrong CRC at once.
	typedef enum int {FLAW_NONE, FLAW_VERSION, FLAW_LENGTH, FLAW_CRC, FLAW_ALL} frame_flaw_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [1:0]         cfg_index;
	logic [7:0]         cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         data_byte;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         status;
	logic [15:0]        sequence_number;
	logic [7:0]         command_mode;
	logic [7:0]         command_valid;
	logic signed [15:0] position;

	// Scoreboard copy of the parser state and its registers.
	logic [3:0]  hunt_pos;
	logic [7:0]  frame_buf [cfp_pkg::FRAME_BYTES];
	logic [15:0] crc_acc;
	logic [7:0]  hdr_first;
	logic [7:0]  hdr_second;
	logic [7:0]  want_version;

	frame_result_t pending_results[$];

	int mismatch_count;
	int quiet_cycles;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_left;

	command_frame_parser_crc16 DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.sequence_number (sequence_number),
		.command_mode    (command_mode),
		.command_valid   (command_valid),
		.position        (position)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// One CRC-16/CCITT-FALSE step, shifting the byte in MSB first.
	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] octet);
		logic [15:0] acc;
		logic        feedback;
		acc = crc;
		for (int k = 7; k >= 0; k--) begin
			feedback = acc[15] ^ octet[k];
			acc = {acc[14:0], 1'b0};
			if (feedback) begin
				acc = acc ^ cfp_pkg::CRC_POLY;
			end
		end
		return acc;
	endfunction

	// Advances the scoreboard parser by one byte and returns the result item
	// that this byte should produce.
	function automatic frame_result_t parse_byte(input logic [7:0] octet);
		frame_result_t r;
		r = '0;
		r.status = cfp_pkg::ST_INCOMPLETE;
		if (hunt_pos == 4'd0) begin
			if (octet == hdr_first) begin
				frame_buf[0] = octet;
				crc_acc = crc16_next(cfp_pkg::CRC_INIT, octet);
				hunt_pos = 4'd1;
			end
		end else if (hunt_pos == 4'd1) begin
			// The second header byte wins over a repeat of the first, which
			// matters when both sync values are the same.
			if (octet == hdr_second) begin
				frame_buf[1] = octet;
				crc_acc = crc16_next(crc_acc, octet);
				hunt_pos = 4'd2;
			end else if (octet == hdr_first) begin
				frame_buf[0] = octet;
				crc_acc = crc16_next(cfp_pkg::CRC_INIT, octet);
			end else begin
				hunt_pos = 4'd0;
			end
		end else begin
			frame_buf[hunt_pos] = octet;
			if (hunt_pos < cfp_pkg::CRC_SPAN) begin
				crc_acc = crc16_next(crc_acc, octet);
			end
			if (hunt_pos == 4'(cfp_pkg::FRAME_BYTES - 1)) begin
				// Frame complete: back to the hunt, checks in fixed order.
				hunt_pos = 4'd0;
				if (frame_buf[2] != want_version) begin
					r.status = cfp_pkg::ST_BAD_VERSION;
				end else if (frame_buf[3] != 8'(cfp_pkg::FRAME_BYTES)) begin
					r.status = cfp_pkg::ST_BAD_LENGTH;
				end else if ({frame_buf[11], frame_buf[10]} != crc_acc) begin
					r.status = cfp_pkg::ST_BAD_CRC;
				end else begin
					r.status = cfp_pkg::ST_VALID;
					r.sequence_number = {frame_buf[5], frame_buf[4]};
					r.command_mode = frame_buf[6];
					r.command_valid = frame_buf[7];
					r.position = {frame_buf[9], frame_buf[8]};
				end
			end else begin
				hunt_pos = hunt_pos + 4'd1;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field_name, input logic [15:0] want,
			input logic [15:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LINES) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field_name, want,
				got);
		end
	endtask

	// Scoreboard. At each rising edge it first checks a result leaving the
	// block, then follows register writes, and last predicts for a byte being
	// taken in. A result trails its byte through both registers, so checking
	// before predicting keeps a too-early result from matching its prediction.
	always @(posedge clk or negedge arst_n) begin
		frame_result_t got;
		frame_result_t want;
		if (!arst_n) begin
			hunt_pos = 4'd0;
			crc_acc = cfp_pkg::CRC_INIT;
			hdr_first = 8'hAA;
			hdr_second = 8'h55;
			want_version = 8'h01;
			pending_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				got = '{status, sequence_number, command_mode, command_valid, position};
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result, status", 16'd0, 16'(got.status));
				end else begin
					want = pending_results.pop_front();
					if (got.status != want.status)
						report_mismatch("status", 16'(want.status), 16'(got.status));
					if (got.sequence_number != want.sequence_number)
						report_mismatch("sequence_number", want.sequence_number,
							got.sequence_number);
					if (got.command_mode != want.command_mode)
						report_mismatch("command_mode", 16'(want.command_mode),
							16'(got.command_mode));
					if (got.command_valid != want.command_valid)
						report_mismatch("command_valid", 16'(want.command_valid),
							16'(got.command_valid));
					if (got.position != want.position)
						report_mismatch("position", want.position, got.position);
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					cfp_pkg::REG_HEADER_FIRST:     hdr_first = cfg_data;
					cfp_pkg::REG_HEADER_SECOND:    hdr_second = cfg_data;
					cfp_pkg::REG_EXPECTED_VERSION: want_version = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				pending_results.push_back(parse_byte(data_byte));
			end
		end
	end

	// Receiver. A requested hold-off is counted down here cycle by cycle;
	// otherwise ready is dropped at random with the current stall rate.
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			out_ready <= 1'b0;
			hold_off_left = hold_off_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: any accepted item on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("command_frame_parser_crc16_test: FAIL");
				$finish;
			end
		end
	end

	// Offers one byte, with random idle cycles ahead of it, and returns at the
	// falling edge after it was taken. Valid is left high so that a following
	// byte goes out back to back.
	task automatic send_byte(input logic [7:0] octet);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= octet;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_octets(input octet_q_t burst);
		foreach (burst[i]) send_byte(burst[i]);
	endtask

	// Stops offering and waits until every predicted result was taken.
	task automatic wait_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	// Full drain: results out, then a few cycles so that nothing is in flight.
	task automatic drain_results();
		wait_results();
		repeat (4) @(negedge clk);
	endtask

	// Writes all three registers plus the unused index. Only called when idle.
	task automatic program_config(input logic [7:0] first_sync, input logic [7:0] second_sync,
			input logic [7:0] version);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_UNUSED;
		cfg_data <= 8'($urandom);
		@(negedge clk);
		cfg_index <= cfp_pkg::REG_HEADER_FIRST;
		cfg_data <= first_sync;
		@(negedge clk);
		cfg_index <= cfp_pkg::REG_HEADER_SECOND;
		cfg_data <= second_sync;
		@(negedge clk);
		cfg_index <= cfp_pkg::REG_EXPECTED_VERSION;
		cfg_data <= version;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Builds a whole 12-byte frame for the current registers, with a correct
	// CRC unless the flaw asks otherwise.
	function automatic octet_q_t make_frame(input frame_flaw_t flaw, input logic [15:0] seq,
			input logic [7:0] mode, input logic [7:0] cmd_flag, input logic [15:0] pos_raw);
		octet_q_t    f;
		logic [7:0]  ver;
		logic [7:0]  len;
		logic [15:0] crc;
		ver = want_version;
		len = 8'(cfp_pkg::FRAME_BYTES);
		if (flaw == FLAW_VERSION || flaw == FLAW_ALL)
			ver = ver ^ 8'($urandom_range(255, 1));
		if (flaw == FLAW_LENGTH || flaw == FLAW_ALL)
			len = len ^ 8'($urandom_range(255, 1));
		f = '{hdr_first, hdr_second, ver, len, seq[7:0], seq[15:8], mode, cmd_flag,
			pos_raw[7:0], pos_raw[15:8]};
		crc = cfp_pkg::CRC_INIT;
		foreach (f[i]) crc = crc16_next(crc, f[i]);
		if (flaw == FLAW_CRC || flaw == FLAW_ALL)
			crc = crc ^ 16'($urandom_range(65535, 1));
		f.push_back(crc[7:0]);
		f.push_back(crc[15:8]);
		return f;
	endfunction

	// Field values lean toward the extremes now and then.
	function automatic logic [15:0] pick_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_octet();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic octet_q_t random_frame(input frame_flaw_t flaw);
		return make_frame(flaw, pick_word(), pick_octet(), pick_octet(), pick_word());
	endfunction

	// Header hunt corner cases leading into a valid frame whose fields sit at
	// their extremes: noise while hunting, a broken header, then a repeated
	// first sync byte that restarts the CRC before the frame proper.
	task automatic test_extreme_frame();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_byte(8'h00);
		send_byte(hdr_first);
		send_byte(8'h00);
		send_byte(hdr_first);
		send_octets(make_frame(FLAW_NONE, 16'hFFFF, 8'h00, 8'hFF, 16'h8000));
	endtask

	// Version, length and CRC all wrong: only the version error may show.
	task automatic test_check_order();
		send_octets(make_frame(FLAW_ALL, 16'h0000, 8'hFF, 8'h00, 16'h7FFF));
		drain_results();
	endtask

	// Mostly well-formed frames with random content, mixed with damaged
	// frames, repeated and broken headers, cut-off frames and line noise.
	task automatic test_random_traffic(input int n_items, input int sender_idle,
			input int receiver_stall);
		octet_q_t   burst;
		int         sent;
		int         pick;
		logic [7:0] other;
		send_idle_pct = sender_idle;
		recv_stall_pct = receiver_stall;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			burst.delete();
			if (pick < 50) begin
				burst = random_frame(FLAW_NONE);
			end else if (pick < 60) begin
				burst = random_frame(FLAW_VERSION);
			end else if (pick < 67) begin
				burst = random_frame(FLAW_LENGTH);
			end else if (pick < 76) begin
				burst = random_frame(FLAW_CRC);
			end else if (pick < 80) begin
				burst = random_frame(FLAW_ALL);
			end else if (pick < 86) begin
				burst = random_frame(FLAW_NONE);
				repeat ($urandom_range(3, 1)) burst.push_front(hdr_first);
			end else if (pick < 92) begin
				do begin
					other = 8'($urandom);
				end while (other == hdr_first || other == hdr_second);
				burst = '{hdr_first, other};
			end else if (pick < 96) begin
				// A frame cut short; the next burst gets absorbed into it.
				burst = random_frame(FLAW_NONE);
				repeat ($urandom_range(11, 1)) void'(burst.pop_back());
			end else begin
				repeat ($urandom_range(6, 1)) burst.push_back(8'($urandom));
			end
			send_octets(burst);
			sent += burst.size();
		end
		drain_results();
	endtask

	// The receiver holds off for a long stretch while frames keep coming, so
	// both stages fill and the input stalls. Afterwards the sender pauses
	// until every result is out before it sends again.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_left = 200;
		repeat (3) send_octets(random_frame(FLAW_NONE));
		wait_results();
		send_octets(random_frame(FLAW_CRC));
		send_octets(random_frame(FLAW_NONE));
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = cfp_pkg::REG_HEADER_FIRST;
		cfg_data = 8'h00;
		in_valid = 1'b0;
		data_byte = 8'h00;
		out_ready = 1'b0;
		mismatch_count = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_left = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset values of the registers first, then settings at the extremes,
		// equal sync bytes, and a random setting.
		test_extreme_frame();
		test_check_order();
		test_random_traffic(200, 0, 0);
		program_config(8'h00, 8'hFF, 8'h00);
		test_random_traffic(200, 72, 0);
		program_config(8'hFF, 8'h00, 8'hFF);
		test_random_traffic(200, 0, 72);
		program_config(8'h5A, 8'h5A, 8'($urandom));
		test_random_traffic(200, 12, 12);
		program_config(8'($urandom), 8'($urandom), 8'($urandom));
		test_backpressure();
		test_random_traffic(160, 0, 0);

		if (mismatch_count == 0) begin
			$display("command_frame_parser_crc16_test: PASS");
		end else begin
			$display("command_frame_parser_crc16_test: FAIL");
		end
		$finish;
	end

endmodule
